[src/bpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator: request codes,
// address constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_REBUILD = 2'd2
  } req_t;

  // Base address of the page pool as seen on the 30-bit result.
  localparam logic [29:0] MEM_BASE = 30'h2000_0000;

  // Highest address bit kept when an address is reduced to a page index.
  localparam int ADDR_TOP_BIT = 28;

  // Bits per map word and the shift that goes with it.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the release page of an accepted request
    logic scan_first;  // read map word zero
    logic scan_next;   // read the next map word of the scan
    logic take;        // claim the lowest free page of the checked word
    logic fail;        // record a failed result
    logic rel_read;    // read the map word of the release page
    logic rel_write;   // set the release page free if it is in range
    logic rebuild;     // free every page, then reserve the low pages
    logic publish;     // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_kind;   // request code on the input channel
    logic       scan_hit;   // checked word has a free page
    logic       scan_last;  // checked word is the last map word
  } ctrl_status_t;

endpackage
`default_nettype wire

[src/bpa_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator channels
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------

// Request channel.
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] page_address;

  modport source (output valid, output req_type, output page_address, input ready);
  modport sink   (input valid, input req_type, input page_address, output ready);
endinterface

// Result channel.
interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [29:0] alloc_address;
  logic        ok;

  modport source (output valid, output alloc_address, output ok, input ready);
  modport sink   (input valid, input alloc_address, input ok, output ready);
endinterface

// Configuration write channel for the reserved page count.
interface bpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/bpa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller of the allocator: sequences the map scan, the release
// read-modify-write and the rebuild, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  input  wire bpa_pkg::ctrl_status_t st,
  output bpa_pkg::ctrl_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REL_RD,
    S_REL_WR,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          case (st.req_kind)
            bpa_pkg::REQ_ALLOC: begin
              cmd.scan_first = 1'b1;
              state_next     = S_SCAN;
            end
            bpa_pkg::REQ_RELEASE: begin
              state_next = S_REL_RD;
            end
            bpa_pkg::REQ_REBUILD: begin
              cmd.rebuild = 1'b1;
              state_next  = S_RESP;
            end
            default: begin
              cmd.fail   = 1'b1;
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (st.scan_hit) begin
          cmd.take   = 1'b1;
          state_next = S_RESP;
        end else if (st.scan_last) begin
          cmd.fail   = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_REL_RD: begin
        cmd.rel_read = 1'b1;
        state_next   = S_REL_WR;
      end
      S_REL_WR: begin
        cmd.rel_write = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/bpa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_datapath
// Free-page map memory with per-word valid bits, first-fit search of one
// word, release update, reserved count register and the result registers.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int NUM_PAGES  = 128,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [1:0]            req_type,
  input  wire logic [31:0]           page_address,
  input  wire logic                  cfg_we,
  input  wire logic [7:0]            cfg_data,
  input  wire bpa_pkg::ctrl_cmd_t    cmd,
  output bpa_pkg::ctrl_status_t      st,
  output logic [29:0]                alloc_address,
  output logic                       ok
);

  localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PG_W      = WIDX_W + bpa_pkg::WORD_SHIFT;
  localparam int LIM_W     = PG_W + 1;
  localparam int ADDR_PG_W = bpa_pkg::ADDR_TOP_BIT + 1 - PAGE_SHIFT;
  localparam logic [LIM_W-1:0]  NUM_LIM   = LIM_W'(NUM_PAGES);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

  // Bits of word w whose page index lies below lim.
  function automatic logic [31:0] page_mask(input logic [LIM_W-1:0]  lim,
                                            input logic [WIDX_W-1:0] w);
    logic [LIM_W-1:0] first;
    logic [LIM_W-1:0] left;
    logic [31:0]      m;
    first = {1'b0, w, 5'd0};
    left  = lim - first;
    if (lim <= first) begin
      m = '0;
    end else if (left >= LIM_W'(bpa_pkg::WORD_BITS)) begin
      m = '1;
    end else begin
      m = (32'd1 << left[4:0]) - 32'd1;
    end
    return m;
  endfunction

  logic [31:0]           map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]  word_ok;
  logic [7:0]            reserved_pages;
  logic [LIM_W-1:0]      res_count;
  logic [PG_W-1:0]       rel_page;
  logic                  rel_in_range;
  logic [WIDX_W-1:0]     scan_idx;
  logic [WIDX_W-1:0]     chk_idx;
  logic [31:0]           rd_data;
  logic                  rd_ok;
  logic [29:0]           res_addr;
  logic                  res_ok;

  logic                  rd_en;
  logic [WIDX_W-1:0]     rd_addr;
  logic [ADDR_PG_W-1:0]  rel_full;
  logic [31:0]           live_mask;
  logic [31:0]           eff_word;
  logic [4:0]            low_bit;
  logic [31:0]           take_word;
  logic [31:0]           rel_word;
  logic                  mem_we;
  logic [31:0]           mem_wd;
  logic [PG_W-1:0]       hit_page;

  // Page index of a release address.
  assign rel_full = page_address[bpa_pkg::ADDR_TOP_BIT:PAGE_SHIFT];

  // Configuration register and release capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_pages <= '0;
    end else if (cfg_we) begin
      reserved_pages <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rel_page     <= PG_W'(rel_full);
      rel_in_range <= (32'(rel_full) < 32'(NUM_PAGES));
    end
  end

  // Map read address: word zero, the next scan word, or the release word.
  always_comb begin
    rd_en = cmd.scan_first || cmd.scan_next || cmd.rel_read;
    if (cmd.scan_first) begin
      rd_addr = '0;
    end else if (cmd.scan_next) begin
      rd_addr = scan_idx;
    end else begin
      rd_addr = rel_page[PG_W-1:bpa_pkg::WORD_SHIFT];
    end
  end

  // Registered map read together with the word's valid bit.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= map_mem[rd_addr];
      rd_ok    <= word_ok[rd_addr];
      chk_idx  <= rd_addr;
      scan_idx <= rd_addr + 1'b1;
    end
  end

  // A word never written since rebuild reads as all live pages free except
  // the reserved ones.
  always_comb begin
    live_mask = page_mask(NUM_LIM, chk_idx);
    if (rd_ok) begin
      eff_word = rd_data & live_mask;
    end else begin
      eff_word = live_mask & ~page_mask(res_count, chk_idx);
    end
  end

  // Lowest free bit of the checked word.
  always_comb begin
    low_bit = '0;
    for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (eff_word[i]) begin
        low_bit = 5'(i);
      end
    end
  end

  assign take_word = eff_word & ~(32'd1 << low_bit);
  assign rel_word  = eff_word | (32'd1 << rel_page[4:0]);
  assign mem_we    = cmd.take || (cmd.rel_write && rel_in_range);
  assign mem_wd    = cmd.take ? take_word : rel_word;
  assign hit_page  = {chk_idx, low_bit};

  // Map memory write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[chk_idx] <= mem_wd;
    end
  end

  // Word valid bits and the reserved count in force since the last rebuild.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_ok   <= '0;
      res_count <= '0;
    end else if (cmd.rebuild) begin
      word_ok <= '0;
      if (32'(reserved_pages) > 32'(NUM_PAGES)) begin
        res_count <= NUM_LIM;
      end else begin
        res_count <= LIM_W'(reserved_pages);
      end
    end else if (mem_we) begin
      word_ok[chk_idx] <= 1'b1;
    end
  end

  // Result of the current request.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_addr <= bpa_pkg::MEM_BASE + (30'(hit_page) << PAGE_SHIFT);
      res_ok   <= 1'b1;
    end else if (cmd.rel_write) begin
      res_addr <= '0;
      res_ok   <= rel_in_range;
    end else if (cmd.rebuild) begin
      res_addr <= '0;
      res_ok   <= 1'b1;
    end else if (cmd.fail) begin
      res_addr <= '0;
      res_ok   <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      alloc_address <= res_addr;
      ok            <= res_ok;
    end
  end

  // Status to the controller.
  assign st.req_kind  = req_type;
  assign st.scan_hit  = |eff_word;
  assign st.scan_last = (chk_idx == LAST_WORD);

endmodule
`default_nettype wire

[src/bitmap_page_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a bitmap of free pages, one bit per page.
//
//   channel  dir  contents
//   req      in   req_type (alloc/release/rebuild), page_address
//   rsp      out  alloc_address, ok
//   cfg      in   data: reserved page count used by rebuild
//
// One request is in work at a time. An allocate reads map words in order
// until one holds a free page, 1 to ceil(NUM_PAGES/32) words; the map
// memory is read one word per cycle. A release reads the map word, then
// modifies and writes it, then gives its result; a rebuild clears the
// per-word valid bits instead of sweeping the map. A stalled result holds
// in the output register while the next request is taken.
// Reset is synchronous and leaves every page free, reserved count zero.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int NUM_PAGES  = 128,
  parameter int PAGE_SHIFT = 12
) (
  input wire logic clk,
  input wire logic rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);

  bpa_pkg::ctrl_cmd_t    cmd;
  bpa_pkg::ctrl_status_t st;

  // The count register can always be written.
  assign cfg.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req.req_type),
    .page_address  (req.page_address),
    .cfg_we        (cfg.valid && cfg.ready),
    .cfg_data      (cfg.data),
    .cmd           (cmd),
    .st            (st),
    .alloc_address (rsp.alloc_address),
    .ok            (rsp.ok)
  );

  // A request in work blocks the next one.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in work");

  // A published result shows up on the result channel.
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> rsp.valid)
    else $error("published result not presented");

  // Only one source writes the result of a request.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.fail, cmd.rel_write, cmd.rebuild}))
    else $error("more than one result source in a cycle");

endmodule
`default_nettype wire

[dv/tb_bitmap_page_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Self-checking testbench for the first-fit bitmap page allocator. A driver
// feeds queued requests onto the request channel. Each accepted request runs
// through a bit-level model of the free-page map, and the model's grant is
// queued. A monitor checks every result field against the oldest queued
// grant. The stimulus starts with directed corner cases. It then runs random
// allocate bursts, fills, releases, rebuilds and noise, under several
// idle/stall mixes and reserved page counts.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;

  localparam int NUM_PAGES   = 128;
  localparam int PAGE_SHIFT  = 12;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  // Request code with no meaning to the block.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [29:0] alloc_address;
    logic        ok;
  } grant_t;

  logic clk;
  logic rst;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();
  bpa_cfg_if cfg_ch ();

  bitmap_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Model state: one bit per page, 1 means free, plus the reserved count.
  logic [NUM_PAGES-1:0] free_pages;
  logic [7:0]           reserved_count;

  page_req_t request_queue[$];
  grant_t    expected_grants[$];

  int        send_idle_pct;
  int        recv_stall_pct;
  int        error_count;
  int        cycle_count;
  page_req_t next_req;
  grant_t    want;

  always #10 clk = ~clk;

  // Compute the grant for one request and update the model map.
  function automatic grant_t predict_request(input logic [1:0] kind,
                                             input logic [31:0] addr);
    grant_t      g;
    logic [16:0] idx;
    g.alloc_address = '0;
    g.ok            = 1'b0;
    if (kind == bpa_pkg::REQ_ALLOC) begin
      for (int p = 0; p < NUM_PAGES; p++) begin
        if (free_pages[p]) begin
          free_pages[p]   = 1'b0;
          g.alloc_address = bpa_pkg::MEM_BASE + (30'(p) << PAGE_SHIFT);
          g.ok            = 1'b1;
          break;
        end
      end
    end else if (kind == bpa_pkg::REQ_RELEASE) begin
      idx = addr[bpa_pkg::ADDR_TOP_BIT:PAGE_SHIFT];
      if (idx < NUM_PAGES) begin
        free_pages[idx] = 1'b1;
        g.ok            = 1'b1;
      end
    end else if (kind == bpa_pkg::REQ_REBUILD) begin
      free_pages = '1;
      for (int p = 0; p < NUM_PAGES && p < reserved_count; p++) begin
        free_pages[p] = 1'b0;
      end
      g.ok = 1'b1;
    end
    return g;
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("Mismatch: %s", msg);
    end
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [31:0] addr);
    page_req_t r;
    r.kind = kind;
    r.addr = addr;
    request_queue.push_back(r);
  endtask

  // Byte address of a page index, with random ignored high and offset bits.
  function automatic logic [31:0] page_addr(input int page);
    return {3'($urandom_range(7)), 17'(page), 12'($urandom)};
  endfunction

  // Wait until every request is accepted and every result has come back.
  task automatic drain_all();
    while (request_queue.size() != 0 || req_ch.valid || expected_grants.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write the reserved page count while the block is idle.
  task automatic write_reserved(input logic [7:0] value);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    reserved_count = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic in short sequences that fill, drain and rebuild the map.
  task automatic gen_random(input int count);
    int left;
    int len;
    int sel;
    left = count;
    while (left > 0) begin
      sel = $urandom_range(0, 19);
      if (sel < 7) begin
        len = $urandom_range(1, 16);
        repeat (len) push_req(bpa_pkg::REQ_ALLOC, $urandom);
      end else if (sel < 12) begin
        len = $urandom_range(1, 16);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            push_req(bpa_pkg::REQ_RELEASE, page_addr($urandom_range(0, 15)));
          end else begin
            push_req(bpa_pkg::REQ_RELEASE, page_addr($urandom_range(0, NUM_PAGES - 1)));
          end
        end
      end else if (sel < 14) begin
        // A long allocate run usually empties the map and hits failures.
        len = $urandom_range(100, 150);
        repeat (len) push_req(bpa_pkg::REQ_ALLOC, $urandom);
      end else if (sel < 15) begin
        len = $urandom_range(1, 8);
        push_req(bpa_pkg::REQ_REBUILD, $urandom);
        repeat (len) push_req(bpa_pkg::REQ_ALLOC, $urandom);
        len++;
      end else begin
        len = 1;
        case ($urandom_range(0, 3))
          0: push_req(bpa_pkg::REQ_RELEASE, $urandom);
          1: push_req(bpa_pkg::REQ_RELEASE, page_addr($urandom_range(NUM_PAGES, 17'h1FFFF)));
          2: push_req(REQ_UNUSED, $urandom);
          default: push_req(bpa_pkg::REQ_RELEASE, page_addr(NUM_PAGES - 1));
        endcase
      end
      left -= len;
    end
  endtask

  // Request driver: presents queued requests and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_grants.push_back(predict_request(req_ch.req_type, req_ch.page_address));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = request_queue.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.req_type     <= next_req.kind;
          req_ch.page_address <= next_req.addr;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random backpressure and field-by-field checking.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_grants.size() == 0) begin
          note_mismatch($sformatf("unexpected result addr=%h ok=%0d",
                                  rsp_ch.alloc_address, rsp_ch.ok));
        end else begin
          want = expected_grants.pop_front();
          if (rsp_ch.alloc_address !== want.alloc_address) begin
            note_mismatch($sformatf("alloc_address expected %h, got %h",
                                    want.alloc_address, rsp_ch.alloc_address));
          end
          if (rsp_ch.ok !== want.ok) begin
            note_mismatch($sformatf("ok expected %0d, got %0d (addr %h)",
                                    want.ok, rsp_ch.ok, want.alloc_address));
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    logic [7:0] reserved_choices[12];
    clk                 = 1'b0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = bpa_pkg::REQ_ALLOC;
    req_ch.page_address = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    free_pages          = '1;
    reserved_count      = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    error_count         = 0;
    cycle_count         = 0;
    reserved_choices    = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'd64, 8'd127, 8'd128,
                            8'd129, 8'd200, 8'd255, 8'd5};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: first allocations, releases in and out of range, a release
    // of a page that is already free, the unused code and a plain rebuild.
    push_req(bpa_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
    push_req(bpa_pkg::REQ_ALLOC, 32'h0000_0000);
    push_req(bpa_pkg::REQ_RELEASE, 32'h2000_0000);
    push_req(bpa_pkg::REQ_RELEASE, 32'hE000_0FFF);
    push_req(bpa_pkg::REQ_ALLOC, $urandom);
    push_req(bpa_pkg::REQ_RELEASE, 32'hFFFF_FFFF);
    push_req(bpa_pkg::REQ_RELEASE, 32'h0008_0000);
    push_req(bpa_pkg::REQ_RELEASE, 32'h1FFF_FFFF);
    push_req(bpa_pkg::REQ_RELEASE, 32'h0007_F000);
    push_req(REQ_UNUSED, 32'hFFFF_FFFF);
    push_req(bpa_pkg::REQ_REBUILD, $urandom);
    drain_all();

    // A reserved count beyond the map leaves no page free.
    write_reserved(8'd255);
    push_req(bpa_pkg::REQ_REBUILD, 32'h0000_0000);
    push_req(bpa_pkg::REQ_ALLOC, $urandom);
    push_req(bpa_pkg::REQ_RELEASE, 32'h2007_FABC);
    push_req(bpa_pkg::REQ_ALLOC, $urandom);
    push_req(bpa_pkg::REQ_ALLOC, $urandom);
    drain_all();

    // Exactly the whole map reserved, then one page handed back.
    write_reserved(8'd128);
    push_req(bpa_pkg::REQ_REBUILD, $urandom);
    push_req(bpa_pkg::REQ_ALLOC, $urandom);
    push_req(bpa_pkg::REQ_RELEASE, 32'h4004_0000);
    push_req(bpa_pkg::REQ_ALLOC, $urandom);
    drain_all();

    write_reserved(8'd3);
    push_req(bpa_pkg::REQ_REBUILD, $urandom);
    push_req(bpa_pkg::REQ_ALLOC, 32'h0000_0000);
    push_req(REQ_UNUSED, 32'h0000_0000);
    push_req(bpa_pkg::REQ_ALLOC, 32'h0000_0000);
    drain_all();

    // Random traffic under four idle/stall mixes, each in drained chunks.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        if ($urandom_range(0, 3) == 0) begin
          write_reserved(8'($urandom_range(0, 255)));
        end else begin
          write_reserved(reserved_choices[$urandom_range(0, 11)]);
        end
        if ($urandom_range(0, 1) == 0) begin
          push_req(bpa_pkg::REQ_REBUILD, $urandom);
        end
        // The last sequence of a chunk can overshoot by up to 149 requests.
        gen_random(60);
        drain_all();
      end
    end

    repeat (20) @(posedge clk);
    if (expected_grants.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
